// ===== hdl/psac_pkg.sv =====
`default_nettype none
package psac_pkg;

    localparam int KEY_W    = 64;
    localparam int TIME_W   = 48;
    localparam int BYTES_W  = 40;
    localparam int CNT_W    = 7;
    localparam int CRE_W    = 16;
    localparam int WIN_W    = 32;

    typedef enum logic [1:0] {
        OP_CREATE = 2'd0,
        OP_REMOVE = 2'd1,
        OP_SWEEP  = 2'd2,
        OP_NONE   = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_BUSY    = 2'd1,
        ST_IGNORED = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        REG_MAX_SESSIONS  = 3'd0,
        REG_CREATES       = 3'd1,
        REG_LIVE_PER_SRC  = 3'd2,
        REG_WINDOW_LEN    = 3'd3,
        REG_BUDGET        = 3'd4,
        REG_MAX_BUFFER    = 3'd5
    } reg_index_t;

    localparam logic [WIN_W-1:0] WINDOW_RESET = WIN_W'(60 * 1000);

endpackage
`default_nettype wire

// ===== hdl/psac_divider.sv =====
`default_nettype none
// Restoring divider, one quotient bit per cycle; divisor never zero here.
module psac_divider
    import psac_pkg::*;
#(
    parameter int DIV_W = 7
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               start,
    input  wire logic [BYTES_W-1:0] dividend,
    input  wire logic [DIV_W-1:0]   divisor,
    output logic                    done,
    output logic [BYTES_W-1:0]      quotient
);
    localparam int CW = $clog2(BYTES_W + 1);

    logic               busy_reg, busy_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [BYTES_W-1:0] quo_reg, quo_next;
    logic [DIV_W:0]     rem_reg, rem_next;
    logic [DIV_W-1:0]   dsr_reg, dsr_next;
    logic               done_reg, done_next;
    logic [DIV_W:0]     trial;

    always_comb begin
        busy_next  = busy_reg;
        count_next = count_reg;
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        dsr_next   = dsr_reg;
        done_next  = 1'b0;
        trial      = {rem_reg[DIV_W-1:0], quo_reg[BYTES_W-1]};
        if (start) begin
            busy_next  = 1'b1;
            count_next = CW'(BYTES_W);
            quo_next   = dividend;
            rem_next   = '0;
            dsr_next   = divisor;
        end else if (busy_reg) begin
            quo_next = {quo_reg[BYTES_W-2:0], 1'b0};
            if (trial >= {1'b0, dsr_reg}) begin
                rem_next    = trial - {1'b0, dsr_reg};
                quo_next[0] = 1'b1;
            end else begin
                rem_next = trial;
            end
            count_next = count_reg - 1'b1;
            if (count_reg == CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end else begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;
endmodule
`default_nettype wire

// ===== hdl/per_source_admission_control_unit.sv =====
`default_nettype none
// Channel | Direction | Handshake            | Payload
// s_      | in        | s_valid / s_ready    | opcode, source_key, session_slot, now_ms
// m_      | out       | m_valid / m_ready    | status, granted_slot, buffer_cap_bytes,
//         |           |                      |   live_sessions
// cfg_    | in        | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One item at a time. A create scans the source memory (one read per cycle) for a key
// match, refetches a matched entry, applies the update, then runs the budget divide.
// A sweep scans and then divides, a remove reads the owner's entry, updates it and
// divides, and an unknown opcode goes straight to the divide.
// Slot valid bits sit in flip-flops; slot owners and source entries sit in memories.
// Reset is synchronous; it clears state, valid bits, live count, config and m_valid.
// A result holds in the output register until taken; the next result holds in the last
// state while that one waits. A new item is accepted whenever the unit is idle.
module per_source_admission_control_unit
    import psac_pkg::*;
#(
    parameter int SESSION_SLOTS  = 64,
    parameter int SOURCE_ENTRIES = 64
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [1:0]         s_opcode,
    input  wire logic [KEY_W-1:0]   s_source_key,
    input  wire logic [5:0]         s_session_slot,
    input  wire logic [TIME_W-1:0]  s_now_ms,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [1:0]              m_status,
    output logic [5:0]              m_granted_slot,
    output logic [BYTES_W-1:0]      m_buffer_cap_bytes,
    output logic [CNT_W-1:0]        m_live_sessions,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [BYTES_W-1:0] cfg_data
);
    localparam int SW = $clog2(SESSION_SLOTS);
    localparam int EW = $clog2(SOURCE_ENTRIES);
    localparam int LT_W = $clog2(SESSION_SLOTS + 1);

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_SCAN   = 8'b0000_0010,
        S_CHECK  = 8'b0000_0100,
        S_RDENT  = 8'b0000_1000,
        S_ENTRY  = 8'b0001_0000,
        S_DIV    = 8'b0010_0000,
        S_WAIT   = 8'b0100_0000,
        S_OUT    = 8'b1000_0000
    } state_t;

    // Source entry payload held in one memory word.
    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [TIME_W-1:0] wstart;
        logic [CRE_W-1:0]  created;
        logic [CNT_W-1:0]  live;
    } entry_t;

    state_t state_reg, state_next;

    // configuration
    logic [CNT_W-1:0]   max_sessions_reg;
    logic [CRE_W-1:0]   creates_reg;
    logic [CNT_W-1:0]   live_per_src_reg;
    logic [WIN_W-1:0]   window_reg;
    logic [BYTES_W-1:0] budget_reg;
    logic [BYTES_W-1:0] max_buf_reg;

    // request
    logic [1:0]         op_reg;
    logic [KEY_W-1:0]   key_reg;
    logic [5:0]         rslot_reg;
    logic [TIME_W-1:0]  now_reg;

    // state stores
    entry_t             src_mem [SOURCE_ENTRIES];
    entry_t             rd_data_reg;
    logic [SOURCE_ENTRIES-1:0] src_valid_reg;
    logic [SESSION_SLOTS-1:0]  slot_valid_reg;
    logic [EW-1:0]      owner_mem [SESSION_SLOTS];
    logic [EW-1:0]      owner_rd_reg;
    logic [LT_W-1:0]    live_total_reg;

    // scan
    logic [EW:0]        idx_reg;       // address issued (one beyond last = done)
    logic               rd_pend_reg;
    logic [EW-1:0]      rd_addr_reg;
    logic               hit_reg;
    logic [EW-1:0]      hit_idx_reg;
    logic               new_src_reg;

    // result
    logic [1:0]         status_reg;
    logic [5:0]         grant_reg;
    logic               m_valid_reg;
    logic [BYTES_W-1:0] cap_reg;
    logic [1:0]         out_status_reg;
    logic [5:0]         out_grant_reg;
    logic [BYTES_W-1:0] out_cap_reg;
    logic [CNT_W-1:0]   out_live_reg;
    logic               out_load;

    // memory port
    logic               mem_we;
    logic [EW-1:0]      mem_waddr;
    entry_t             mem_wdata;
    logic               mem_re;
    logic [EW-1:0]      mem_raddr;
    logic               own_we;

    // divider
    logic               div_start, div_done;
    logic [BYTES_W-1:0] div_quo;
    logic [LT_W-1:0]    div_n;

    // lowest free slot
    logic               slot_free;
    logic [SW-1:0]      slot_free_idx;
    always_comb begin
        slot_free     = 1'b0;
        slot_free_idx = '0;
        for (int i = SESSION_SLOTS - 1; i >= 0; i--) begin
            if (!slot_valid_reg[i]) begin
                slot_free     = 1'b1;
                slot_free_idx = SW'(i);
            end
        end
    end

    // lowest free source entry
    logic               src_free;
    logic [EW-1:0]      src_free_idx;
    always_comb begin
        src_free     = 1'b0;
        src_free_idx = '0;
        for (int i = SOURCE_ENTRIES - 1; i >= 0; i--) begin
            if (!src_valid_reg[i]) begin
                src_free     = 1'b1;
                src_free_idx = EW'(i);
            end
        end
    end

    function automatic logic expired_f(input logic [TIME_W-1:0] now,
                                       input logic [TIME_W-1:0] ws,
                                       input logic [WIN_W-1:0]  wl);
        logic [TIME_W-1:0] d;
        d = now - ws;
        return (now >= ws) && (d >= TIME_W'(wl));
    endfunction

    // Current entry word: a freshly installed source reads as a blank window.
    entry_t           cur;
    logic             cur_exp;
    logic [CRE_W-1:0] cre_eff;
    logic             quota_ok;
    logic             in_range;
    logic             rm_ok;
    always_comb begin
        cur = rd_data_reg;
        if (new_src_reg) begin
            cur.key     = key_reg;
            cur.wstart  = now_reg;
            cur.created = '0;
            cur.live    = '0;
        end
        cur_exp  = expired_f(now_reg, cur.wstart, window_reg);
        cre_eff  = cur_exp ? '0 : cur.created;
        quota_ok = (cre_eff < creates_reg) && (cur.live < live_per_src_reg);
        in_range = (32'(rslot_reg) < 32'(SESSION_SLOTS));
        rm_ok    = in_range && slot_valid_reg[SW'(rslot_reg)];
    end

    logic [EW-1:0] rm_owner;
    assign rm_owner = owner_rd_reg;

    always_ff @(posedge aclk) begin
        if (mem_we) src_mem[mem_waddr] <= mem_wdata;
        if (mem_re) rd_data_reg <= src_mem[mem_raddr];
        if (own_we) owner_mem[slot_free_idx] <= hit_idx_reg;
        if (s_valid && s_ready) owner_rd_reg <= owner_mem[SW'(s_session_slot)];
    end

    assign s_ready   = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign div_n     = (live_total_reg == '0) ? LT_W'(1) : live_total_reg;
    assign div_start = (state_reg == S_DIV);
    assign out_load  = (state_reg == S_OUT) && (!m_valid_reg || m_ready);
    assign own_we    = (state_reg == S_ENTRY) && (op_reg == OP_CREATE)
                       && (status_reg == ST_OK) && quota_ok;

    psac_divider #(.DIV_W(LT_W)) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (budget_reg),
        .divisor  (div_n),
        .done     (div_done),
        .quotient (div_quo)
    );

    always_comb begin
        state_next = state_reg;
        mem_we     = 1'b0;
        mem_waddr  = hit_idx_reg;
        mem_wdata  = cur;
        mem_re     = 1'b0;
        mem_raddr  = idx_reg[EW-1:0];
        case (state_reg)
            S_IDLE: begin
                if (s_valid && s_ready) begin
                    case (opcode_t'(s_opcode))
                        OP_CREATE, OP_SWEEP: state_next = S_SCAN;
                        OP_REMOVE:           state_next = S_RDENT;
                        default:             state_next = S_DIV;
                    endcase
                end
            end
            S_SCAN: begin
                // issue one read per cycle, consume previous
                if (idx_reg < (EW+1)'(SOURCE_ENTRIES)) mem_re = 1'b1;
                else if (!rd_pend_reg) state_next = S_CHECK;
            end
            S_RDENT: begin
                mem_re    = 1'b1;
                mem_raddr = rm_owner;
                state_next = S_ENTRY;
            end
            S_CHECK: begin
                // refetch the matched entry for the update
                if (op_reg == OP_CREATE && hit_reg) begin
                    mem_re    = 1'b1;
                    mem_raddr = hit_idx_reg;
                end
                state_next = (op_reg == OP_CREATE) ? S_ENTRY : S_DIV;
            end
            S_ENTRY: begin
                state_next = S_DIV;
                if (op_reg == OP_CREATE && status_reg == ST_OK) begin
                    mem_we = 1'b1;
                    mem_wdata = cur;
                    if (cur_exp) begin
                        mem_wdata.wstart  = now_reg;
                        mem_wdata.created = '0;
                    end
                    if (quota_ok) begin
                        mem_wdata.created = mem_wdata.created + 1'b1;
                        if (cur.live != 7'd127) mem_wdata.live = cur.live + 1'b1;
                    end
                end else if (op_reg == OP_REMOVE && rm_ok) begin
                    mem_we    = 1'b1;
                    mem_waddr = rm_owner;
                    mem_wdata = rd_data_reg;
                    if (rd_data_reg.live != '0) mem_wdata.live = rd_data_reg.live - 1'b1;
                end
            end
            S_DIV:  state_next = S_WAIT;
            S_WAIT: if (div_done) state_next = S_OUT;
            S_OUT:  if (out_load) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= S_IDLE;
            max_sessions_reg <= 7'd64;
            creates_reg      <= 16'd10;
            live_per_src_reg <= 7'd4;
            window_reg       <= WINDOW_RESET;
            budget_reg       <= BYTES_W'(268435456);
            max_buf_reg      <= BYTES_W'(16777216);
            src_valid_reg    <= '0;
            slot_valid_reg   <= '0;
            live_total_reg   <= '0;
            m_valid_reg      <= 1'b0;
            rd_pend_reg      <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready) begin
                case (reg_index_t'(cfg_index))
                    REG_MAX_SESSIONS: max_sessions_reg <= cfg_data[CNT_W-1:0];
                    REG_CREATES:      creates_reg      <= cfg_data[CRE_W-1:0];
                    REG_LIVE_PER_SRC: live_per_src_reg <= cfg_data[CNT_W-1:0];
                    REG_WINDOW_LEN:   window_reg       <= cfg_data[WIN_W-1:0];
                    REG_BUDGET:       budget_reg       <= cfg_data;
                    REG_MAX_BUFFER:   max_buf_reg      <= cfg_data;
                    default: ;
                endcase
            end
            if (out_load) m_valid_reg <= 1'b1;
            else if (m_valid_reg && m_ready) m_valid_reg <= 1'b0;
            rd_pend_reg <= mem_re && (state_reg == S_SCAN);

            case (state_reg)
                S_SCAN: begin
                    // drop idle expired sources on sweep
                    if (rd_pend_reg && op_reg == OP_SWEEP
                        && src_valid_reg[rd_addr_reg] && rd_data_reg.live == '0
                        && expired_f(now_reg, rd_data_reg.wstart, window_reg))
                        src_valid_reg[rd_addr_reg] <= 1'b0;
                end
                S_CHECK: begin
                    if (op_reg == OP_CREATE) begin
                        if (32'(live_total_reg) >= 32'(max_sessions_reg) || !slot_free) begin
                            status_reg <= ST_BUSY;
                        end else if (hit_reg) begin
                            status_reg <= ST_OK;
                        end else if (src_free) begin
                            status_reg <= ST_OK;
                            new_src_reg <= 1'b1;
                            hit_idx_reg <= src_free_idx;
                            src_valid_reg[src_free_idx] <= 1'b1;
                        end else begin
                            status_reg <= ST_BUSY;
                        end
                    end
                end
                S_ENTRY: begin
                    if (op_reg == OP_CREATE && status_reg == ST_OK) begin
                        if (quota_ok) begin
                            slot_valid_reg[slot_free_idx] <= 1'b1;
                            live_total_reg <= live_total_reg + 1'b1;
                            grant_reg      <= 6'(slot_free_idx);
                        end else begin
                            status_reg <= ST_BUSY;
                        end
                    end else if (op_reg == OP_REMOVE && rm_ok) begin
                        slot_valid_reg[SW'(rslot_reg)] <= 1'b0;
                        if (live_total_reg != '0) live_total_reg <= live_total_reg - 1'b1;
                        if (src_valid_reg[rm_owner] && mem_wdata.live == '0
                            && expired_f(now_reg, rd_data_reg.wstart, window_reg))
                            src_valid_reg[rm_owner] <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
        // payload and scan bookkeeping
        if (s_valid && s_ready) begin
            op_reg      <= s_opcode;
            key_reg     <= s_source_key;
            rslot_reg   <= s_session_slot;
            now_reg     <= s_now_ms;
            idx_reg     <= '0;
            hit_reg     <= 1'b0;
            new_src_reg <= 1'b0;
            grant_reg   <= '0;
            hit_idx_reg <= '0;
            case (opcode_t'(s_opcode))
                OP_CREATE, OP_SWEEP: status_reg <= ST_OK;
                OP_REMOVE: status_reg <= ST_OK;
                default:   status_reg <= ST_IGNORED;
            endcase
        end
        if (state_reg == S_RDENT && !rm_ok) status_reg <= ST_IGNORED;
        if (state_reg == S_SCAN) begin
            if (mem_re) begin
                rd_addr_reg <= idx_reg[EW-1:0];
                idx_reg     <= idx_reg + 1'b1;
            end
            if (rd_pend_reg && op_reg == OP_CREATE) begin
                if (src_valid_reg[rd_addr_reg] && rd_data_reg.key == key_reg && !hit_reg) begin
                    hit_reg     <= 1'b1;
                    hit_idx_reg <= rd_addr_reg;
                end
            end
        end
        if (state_reg == S_WAIT && div_done) begin
            cap_reg <= (div_quo < max_buf_reg) ? div_quo : max_buf_reg;
        end
        // hold the finished result for the output channel
        if (out_load) begin
            out_status_reg <= status_reg;
            out_grant_reg  <= grant_reg;
            out_cap_reg    <= cap_reg;
            out_live_reg   <= CNT_W'(live_total_reg);
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_status           = out_status_reg;
    assign m_granted_slot     = out_grant_reg;
    assign m_buffer_cap_bytes = out_cap_reg;
    assign m_live_sessions    = out_live_reg;

    // assertions
    a_live_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        live_total_reg <= LT_W'(SESSION_SLOTS))
        else $error("live total beyond slot count");
    a_count_match: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_IDLE |-> $countones(slot_valid_reg) == int'(live_total_reg))
        else $error("live total disagrees with slot valid bits");
    a_hold_out: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status)
            && $stable(m_buffer_cap_bytes) && $stable(m_live_sessions))
        else $error("result dropped while stalled");
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second item accepted while one is in progress");
endmodule
`default_nettype wire
